// ----- rtl/ias_pkg.sv -----
package ias_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CNT_W  = 6;
    // Common width for comparing the 6-bit position with a count of up to 64.
    localparam int unsigned CMP_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT    = 2'd0,
        MODE_DELETE    = 2'd1,
        MODE_PARTITION = 2'd2,
        MODE_DISPLAY   = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        t_status                  status;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } t_result;

endpackage

// ----- rtl/ias_if.sv -----
interface ias_in_if import ias_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, mode, position, data_in, input ready);
    modport sink   (input valid, mode, position, data_in, output ready);
endinterface

interface ias_out_if import ias_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
    logic                     last;

    modport source (output valid, data_out, status, count, last, input ready);
    modport sink   (input valid, data_out, status, count, last, output ready);
endinterface

// ----- rtl/ias_seq.sv -----
module ias_seq import ias_pkg::*; #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_mode                    i_mode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_data_in,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_EMIT    = 17'h00002,
        S_INS_RD  = 17'h00004,
        S_INS_WR  = 17'h00008,
        S_DEL_RD0 = 17'h00010,
        S_DEL_SV  = 17'h00020,
        S_DEL_RD  = 17'h00040,
        S_DEL_WR  = 17'h00080,
        S_P_LOOP  = 17'h00100,
        S_P_SCI   = 17'h00200,
        S_P_CHI   = 17'h00400,
        S_P_SCJ   = 17'h00800,
        S_P_CHJ   = 17'h01000,
        S_P_SWP   = 17'h02000,
        S_P_SW2   = 17'h04000,
        S_DSP_RD  = 17'h08000,
        S_DSP_OUT = 17'h10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_jp, n_jp;
    logic [CW-1:0]     r_pos, n_pos;
    logic [DATA_W-1:0] r_data, n_data;
    logic [DATA_W-1:0] r_pdata, n_pdata;
    t_status           r_pstat, n_pstat;
    logic [DATA_W-1:0] r_vi, n_vi;
    logic [DATA_W-1:0] r_vj, n_vj;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_mem [CAPACITY];

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [CW-1:0]     idx_inc, idx_dec, jp_dec;
    logic [CMP_W-1:0]  pos_cmp, cnt_cmp, cap_cmp;

    assign idx_inc = r_idx + CW'(1);
    assign idx_dec = r_idx - CW'(1);
    assign jp_dec  = r_jp - CW'(1);
    assign pos_cmp = CMP_W'(i_position);
    assign cnt_cmp = CMP_W'(r_count);
    assign cap_cmp = CMP_W'(CAPACITY);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_jp      = r_jp;
        n_pos     = r_pos;
        n_data    = r_data;
        n_pdata   = r_pdata;
        n_pstat   = r_pstat;
        n_vi      = r_vi;
        n_vj      = r_vj;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_data;
        mem_re    = 1'b0;
        mem_raddr = '0;
        o_res_valid = 1'b0;
        o_res = '{data_out: r_pdata, status: r_pstat,
                  count: CNT_W'(r_count), last: 1'b1};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pdata = '0;
                    n_pstat = ST_OK;
                    n_data  = i_data_in;
                    case (i_mode)
                        MODE_INSERT: begin
                            if (pos_cmp > cnt_cmp) begin
                                n_pstat = ST_BAD_INDEX;
                                n_state = S_EMIT;
                            end else if (cnt_cmp >= cap_cmp) begin
                                n_pstat = ST_FULL;
                                n_state = S_EMIT;
                            end else begin
                                n_pos   = CW'(i_position);
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        MODE_DELETE: begin
                            if (pos_cmp >= cnt_cmp) begin
                                n_pstat = ST_BAD_INDEX;
                                n_state = S_EMIT;
                            end else begin
                                n_pos   = CW'(i_position);
                                n_state = S_DEL_RD0;
                            end
                        end
                        MODE_PARTITION: begin
                            n_idx   = '0;
                            n_jp    = r_count;
                            n_state = S_P_LOOP;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_pstat = ST_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DSP_RD;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_INS_RD: begin
                if (r_idx > r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec[AW-1:0];
                    n_state   = S_INS_WR;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = r_data;
                    n_count   = r_count + CW'(1);
                    n_state   = S_EMIT;
                end
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = idx_dec;
                n_state   = S_INS_RD;
            end
            S_DEL_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = r_pos[AW-1:0];
                n_idx     = r_pos;
                n_state   = S_DEL_SV;
            end
            S_DEL_SV: begin
                n_pdata = r_rdata;
                n_state = S_DEL_RD;
            end
            S_DEL_RD: begin
                if (idx_inc < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc[AW-1:0];
                    n_state   = S_DEL_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_EMIT;
                end
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = idx_inc;
                n_state   = S_DEL_RD;
            end
            S_P_LOOP: begin
                if (idx_inc < r_jp) begin
                    n_state = S_P_SCI;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_P_SCI: begin
                if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_state   = S_P_CHI;
                end else begin
                    n_state = S_P_SCJ;
                end
            end
            S_P_CHI: begin
                if (r_rdata[DATA_W-1]) begin
                    n_idx   = idx_inc;
                    n_state = S_P_SCI;
                end else begin
                    n_vi    = r_rdata;
                    n_state = S_P_SCJ;
                end
            end
            S_P_SCJ: begin
                if (r_jp != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = jp_dec[AW-1:0];
                    n_state   = S_P_CHJ;
                end else begin
                    n_state = S_P_SWP;
                end
            end
            S_P_CHJ: begin
                if (!r_rdata[DATA_W-1]) begin
                    n_jp    = jp_dec;
                    n_state = S_P_SCJ;
                end else begin
                    n_vj    = r_rdata;
                    n_state = S_P_SWP;
                end
            end
            S_P_SWP: begin
                if (idx_inc < r_jp) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = r_vj;
                    n_state   = S_P_SW2;
                end else begin
                    n_state = S_P_LOOP;
                end
            end
            S_P_SW2: begin
                mem_we    = 1'b1;
                mem_waddr = jp_dec[AW-1:0];
                mem_wdata = r_vi;
                n_state   = S_P_LOOP;
            end
            S_DSP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_DSP_OUT;
            end
            S_DSP_OUT: begin
                o_res_valid = 1'b1;
                o_res = '{data_out: r_rdata, status: ST_OK,
                          count: CNT_W'(r_count), last: (idx_inc == r_count)};
                if (i_res_ready) begin
                    n_idx = idx_inc;
                    if (idx_inc == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DSP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_jp    <= n_jp;
        r_pos   <= n_pos;
        r_data  <= n_data;
        r_pdata <= n_pdata;
        r_pstat <= n_pstat;
        r_vi    <= n_vi;
        r_vj    <= n_vj;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(CAPACITY) >= r_count)
        else $error("element count exceeds capacity");

    // No result is offered while a new transaction can be taken.
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_res_valid)
        else $error("result offered while idle");

    // The final result of a transaction returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.last) |=> (r_state == S_IDLE))
        else $error("sequencer not idle after final result");

    // The partition pointers never cross and stay inside the stored range.
    a_part_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_P_LOOP) || (r_state == S_P_SCI) || (r_state == S_P_CHI) ||
         (r_state == S_P_SCJ) || (r_state == S_P_CHJ) || (r_state == S_P_SWP) ||
         (r_state == S_P_SW2)) |-> ((r_idx <= r_jp) && (r_jp <= r_count)))
        else $error("partition pointers crossed");

endmodule

// ----- rtl/indexed_array_store.sv -----
// Channel   Modport           Payload                                Moves
// i_in      ias_in_if.sink    mode, position, data_in                one operation request
// o_out     ias_out_if.source data_out, status, count, last          one result, or one per element on display
//
// Each request is handled by a small sequencer around one element memory:
// every element move is a read and then a write. Insert shifts the elements
// at and above the position up and writes the new one; delete saves the
// element at the position and shifts the ones above it down; partition
// scans from both ends and swaps; display reads each element in turn.
// Errors and an empty display go straight to the result. i_in.ready is high
// only while the sequencer is idle; one request is worked on at a time.
// Reset (synchronous, active low) clears the count and the sequencer; the
// memory itself is not cleared, since only entries below the count are read.
// A stalled o_out holds the output register and the sequencer waits behind it.
module indexed_array_store import ias_pkg::*; #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ias_in_if.sink    i_in,
    ias_out_if.source o_out
);

    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_ovalid;
    t_result r_res;

    // The sequencer owns the element memory and the count; it hands each
    // result to the output register below as soon as the register is free.
    ias_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (t_mode'(i_in.mode)),
        .i_position  (i_in.position),
        .i_data_in   (i_in.data_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The output register accepts a new result when it is empty or when its
    // current transaction completes in the same cycle.
    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.data_out = r_res.data_out;
    assign o_out.status   = r_res.status;
    assign o_out.count    = r_res.count;
    assign o_out.last     = r_res.last;

endmodule
